@@ sv/id3_pkg.sv @@
// shared types, constants and helpers for the id3v2 comment extractor
// no dependencies; used by id3_parser and id3v2_comment_extractor
`timescale 1ns / 1ps
`default_nettype none

package id3_pkg;

    localparam int POSITION_BITS = 32;
    localparam int CMP_W         = 33;
    localparam int TAG_W         = 28;
    localparam int REM_W         = 32;
    localparam int IDX_W         = 4;
    localparam int LIMIT_W       = 16;

    localparam logic [LIMIT_W-1:0] SCAN_LIMIT_RST = 16'd10000;
    localparam logic [7:0]         EXT_FLAG       = 8'h40;
    localparam logic [IDX_W-1:0]   HDR_LAST_IDX   = 4'd9;
    localparam logic [IDX_W-1:0]   FLAGS_IDX      = 4'd5;
    localparam logic [IDX_W-1:0]   SIZE_IDX       = 4'd6;
    localparam logic [IDX_W-1:0]   MAGIC_LEN      = 4'd3;
    localparam logic [IDX_W-1:0]   WORD_LEN       = 4'd4;
    localparam logic [IDX_W-1:0]   SIZE_END       = 4'd8;
    localparam logic [IDX_W-1:0]   LANG_LAST_IDX  = 4'd2;
    localparam logic [CMP_W-1:0]   HEADER_LEN     = 33'd10;
    localparam logic [REM_W-1:0]   EXT_BASE       = 32'd6;
    localparam logic [31:0]        COMM_ID        = 32'h434F_4D4D;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NO_TAG  = 2'd1;
    localparam logic [1:0] ST_NO_COMM = 2'd2;

    typedef enum logic [3:0] {
        PH_HEADER    = 4'd0,
        PH_EXT       = 4'd1,
        PH_EXT_SKIP  = 4'd2,
        PH_FRAME_HDR = 4'd3,
        PH_SKIP      = 4'd4,
        PH_ENC       = 4'd5,
        PH_LANG      = 4'd6,
        PH_DESC      = 4'd7,
        PH_TEXT      = 4'd8
    } phase_t;

    typedef struct packed {
        logic [7:0] stream_byte;
        logic       start_of_file;
    } id3_in_t;

    typedef struct packed {
        logic [7:0] comment_byte;
        logic       byte_valid;
        logic       last;
        logic [1:0] status;
    } id3_out_t;

    // expected "ID3" letters by header offset
    function automatic logic [7:0] magic_letter(input logic [1:0] idx);
        logic [7:0] letter;
        unique case (idx)
            2'd0:    letter = 8'h49;
            2'd1:    letter = 8'h44;
            2'd2:    letter = 8'h33;
            default: letter = 8'h00;
        endcase
        return letter;
    endfunction

endpackage

`default_nettype wire

@@ sv/id3_parser.sv @@
// tag and frame walker: parse state registers plus per-beat next-state logic
// depends on id3_pkg
`timescale 1ns / 1ps
`default_nettype none

module id3_parser (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             beat_en,
    input  wire id3_pkg::id3_in_t                 beat,
    input  wire logic [id3_pkg::LIMIT_W-1:0]      scan_limit,
    output logic                                  res_valid,
    output id3_pkg::id3_out_t                     res
);

    id3_pkg::phase_t                     phase_reg, phase_next, cur_phase;
    logic [id3_pkg::POSITION_BITS-1:0]   pos_reg, pos_next, cur_pos;
    logic [id3_pkg::IDX_W-1:0]           idx_reg, idx_next, cur_idx;
    logic [id3_pkg::TAG_W-1:0]           tag_len_reg, tag_len_next, cur_tag_len;
    logic                                ext_reg, ext_next, cur_ext;
    logic [31:0]                         ftag_reg, ftag_next, cur_ftag;
    logic [id3_pkg::REM_W-1:0]           rem_reg, rem_next, cur_rem;
    logic                                done_reg, done_next, cur_done;
    logic [id3_pkg::REM_W-1:0]           rem_dec;
    logic [id3_pkg::CMP_W-1:0]           tag_end;
    logic [7:0]                          b;

    // start of file restarts parsing before this beat is processed
    always_comb begin
        if (beat.start_of_file) begin
            cur_phase   = id3_pkg::PH_HEADER;
            cur_pos     = '0;
            cur_idx     = '0;
            cur_tag_len = '0;
            cur_ext     = 1'b0;
            cur_ftag    = '0;
            cur_rem     = '0;
            cur_done    = 1'b0;
        end else begin
            cur_phase   = phase_reg;
            cur_pos     = pos_reg;
            cur_idx     = idx_reg;
            cur_tag_len = tag_len_reg;
            cur_ext     = ext_reg;
            cur_ftag    = ftag_reg;
            cur_rem     = rem_reg;
            cur_done    = done_reg;
        end
    end

    assign b       = beat.stream_byte;
    assign rem_dec = cur_rem - id3_pkg::REM_W'(1);
    assign tag_end = id3_pkg::CMP_W'(cur_tag_len) + id3_pkg::HEADER_LEN;

    always_comb begin
        phase_next   = cur_phase;
        pos_next     = cur_pos;
        idx_next     = cur_idx;
        tag_len_next = cur_tag_len;
        ext_next     = cur_ext;
        ftag_next    = cur_ftag;
        rem_next     = cur_rem;
        done_next    = cur_done;
        res_valid    = 1'b0;
        res          = '0;

        if (!cur_done) begin
            if (cur_pos != '1) begin
                pos_next = cur_pos + id3_pkg::POSITION_BITS'(1);
            end
            unique case (cur_phase)
                id3_pkg::PH_HEADER: begin
                    if (cur_idx < id3_pkg::MAGIC_LEN &&
                        b != id3_pkg::magic_letter(cur_idx[1:0])) begin
                        res_valid  = 1'b1;
                        res.last   = 1'b1;
                        res.status = id3_pkg::ST_NO_TAG;
                    end else begin
                        if (cur_idx == id3_pkg::FLAGS_IDX) begin
                            ext_next = (b & id3_pkg::EXT_FLAG) != '0;
                        end
                        if (cur_idx >= id3_pkg::SIZE_IDX) begin
                            // syncsafe: seven bits per byte
                            tag_len_next = {cur_tag_len[id3_pkg::TAG_W-8:0], b[6:0]};
                        end
                        if (cur_idx >= id3_pkg::HDR_LAST_IDX) begin
                            idx_next = '0;
                            if (cur_ext) begin
                                phase_next = id3_pkg::PH_EXT;
                                rem_next   = '0;
                            end else begin
                                phase_next = id3_pkg::PH_FRAME_HDR;
                            end
                        end else begin
                            idx_next = cur_idx + id3_pkg::IDX_W'(1);
                        end
                    end
                end
                id3_pkg::PH_EXT: begin
                    if (cur_idx < id3_pkg::WORD_LEN) begin
                        rem_next = {cur_rem[id3_pkg::REM_W-9:0], b};
                    end
                    if (cur_idx >= id3_pkg::HDR_LAST_IDX) begin
                        idx_next = '0;
                        if (cur_rem > id3_pkg::EXT_BASE) begin
                            rem_next   = cur_rem - id3_pkg::EXT_BASE;
                            phase_next = id3_pkg::PH_EXT_SKIP;
                        end else begin
                            phase_next = id3_pkg::PH_FRAME_HDR;
                        end
                    end else begin
                        idx_next = cur_idx + id3_pkg::IDX_W'(1);
                    end
                end
                id3_pkg::PH_EXT_SKIP, id3_pkg::PH_SKIP: begin
                    if (cur_rem != '0) begin
                        rem_next = rem_dec;
                    end
                    if (cur_rem <= id3_pkg::REM_W'(1)) begin
                        phase_next = id3_pkg::PH_FRAME_HDR;
                        idx_next   = '0;
                    end
                end
                id3_pkg::PH_FRAME_HDR: begin
                    if (cur_idx == '0 &&
                        (id3_pkg::CMP_W'(cur_pos) >= tag_end ||
                         id3_pkg::CMP_W'(cur_pos) > id3_pkg::CMP_W'(scan_limit))) begin
                        res_valid  = 1'b1;
                        res.last   = 1'b1;
                        res.status = id3_pkg::ST_NO_COMM;
                    end else begin
                        if (cur_idx < id3_pkg::WORD_LEN) begin
                            ftag_next = {cur_ftag[23:0], b};
                        end else if (cur_idx < id3_pkg::SIZE_END) begin
                            rem_next = {cur_rem[id3_pkg::REM_W-9:0], b};
                        end
                        if (cur_idx >= id3_pkg::HDR_LAST_IDX) begin
                            idx_next = '0;
                            // empty frames go straight to the next header
                            if (cur_rem == '0) begin
                                phase_next = id3_pkg::PH_FRAME_HDR;
                            end else if (cur_ftag == id3_pkg::COMM_ID) begin
                                phase_next = id3_pkg::PH_ENC;
                            end else begin
                                phase_next = id3_pkg::PH_SKIP;
                            end
                        end else begin
                            idx_next = cur_idx + id3_pkg::IDX_W'(1);
                        end
                    end
                end
                id3_pkg::PH_ENC: begin
                    rem_next = rem_dec;
                    if (b != 8'd0) begin
                        if (rem_dec == '0) begin
                            phase_next = id3_pkg::PH_FRAME_HDR;
                            idx_next   = '0;
                        end else begin
                            phase_next = id3_pkg::PH_SKIP;
                        end
                    end else if (rem_dec == '0) begin
                        res_valid  = 1'b1;
                        res.last   = 1'b1;
                        res.status = id3_pkg::ST_OK;
                    end else begin
                        phase_next = id3_pkg::PH_LANG;
                        idx_next   = '0;
                    end
                end
                id3_pkg::PH_LANG: begin
                    rem_next = rem_dec;
                    if (rem_dec == '0) begin
                        res_valid  = 1'b1;
                        res.last   = 1'b1;
                        res.status = id3_pkg::ST_OK;
                    end else if (cur_idx >= id3_pkg::LANG_LAST_IDX) begin
                        phase_next = id3_pkg::PH_DESC;
                        idx_next   = '0;
                    end else begin
                        idx_next = cur_idx + id3_pkg::IDX_W'(1);
                    end
                end
                id3_pkg::PH_DESC: begin
                    rem_next = rem_dec;
                    if (rem_dec == '0) begin
                        res_valid  = 1'b1;
                        res.last   = 1'b1;
                        res.status = id3_pkg::ST_OK;
                    end else if (b == 8'd0) begin
                        phase_next = id3_pkg::PH_TEXT;
                    end
                end
                id3_pkg::PH_TEXT: begin
                    rem_next         = rem_dec;
                    res_valid        = 1'b1;
                    res.comment_byte = b;
                    res.byte_valid   = 1'b1;
                    res.last         = (rem_dec == '0);
                    res.status       = id3_pkg::ST_OK;
                end
                default: begin
                    done_next = 1'b1;
                end
            endcase
            if (res_valid && res.last) begin
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= id3_pkg::PH_HEADER;
            pos_reg     <= '0;
            idx_reg     <= '0;
            tag_len_reg <= '0;
            ext_reg     <= 1'b0;
            ftag_reg    <= '0;
            rem_reg     <= '0;
            done_reg    <= 1'b0;
        end else if (beat_en) begin
            phase_reg   <= phase_next;
            pos_reg     <= pos_next;
            idx_reg     <= idx_next;
            tag_len_reg <= tag_len_next;
            ext_reg     <= ext_next;
            ftag_reg    <= ftag_next;
            rem_reg     <= rem_next;
            done_reg    <= done_next;
        end
    end

endmodule

`default_nettype wire

@@ sv/id3v2_comment_extractor.sv @@
// a byte is held in the input register, then parsed into the result register
// throughput: one byte per cycle; set by the single parse step between input and
// result registers, which advance together whenever the result register is free
// reset: synchronous active-low aresetn clears both stages and the parse state,
// and loads scan_limit with 10000; the first byte after reset is position 0
`timescale 1ns / 1ps
`default_nettype none

module id3v2_comment_extractor (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_valid,
    output logic                                s_ready,
    input  wire id3_pkg::id3_in_t               s_data,
    output logic                                m_valid,
    input  wire logic                           m_ready,
    output id3_pkg::id3_out_t                   m_data,
    input  wire logic                           cfg_wr_en,
    input  wire logic [id3_pkg::LIMIT_W-1:0]    cfg_wr_data
);

    logic [id3_pkg::LIMIT_W-1:0] scan_limit_reg;
    id3_pkg::id3_in_t            in_data_reg;
    logic                        in_valid_reg, in_valid_next;
    id3_pkg::id3_out_t           out_data_reg;
    logic                        out_valid_reg, out_valid_next;
    logic                        advance;
    logic                        res_valid;
    id3_pkg::id3_out_t           res;

    // a held beat is parsed once the result register can take its outcome
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

    id3_parser u_parser (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .beat_en    (advance),
        .beat       (in_data_reg),
        .scan_limit (scan_limit_reg),
        .res_valid  (res_valid),
        .res        (res)
    );

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (advance) begin
            out_valid_next = res_valid;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scan_limit_reg <= id3_pkg::SCAN_LIMIT_RST;
            in_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                scan_limit_reg <= cfg_wr_data;
            end
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
        if (advance && res_valid) begin
            out_data_reg <= res;
        end
    end

`ifndef SYNTHESIS
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && s_ready)
        else $error("stages not empty after reset");

    a_stall_only_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> in_valid_reg && out_valid_reg && !m_ready)
        else $error("input stalled without a full pipeline");

    a_no_data_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.byte_valid |-> m_data.last && m_data.comment_byte == 8'd0)
        else $error("status beat not marked last");

    a_error_status_no_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.status != id3_pkg::ST_OK |-> !m_data.byte_valid)
        else $error("comment byte carries error status");
`endif

endmodule

`default_nettype wire
